// ===== hw/rtl/frag_pkg.sv =====
package frag_pkg;

    // header layout
    localparam int HDR_BYTES = 10;
    localparam int POS_W     = 11;
    localparam logic [POS_W-1:0] POS_MAX = 11'd2047;
    localparam int DIV_W     = 17;
    localparam int DIV_STEPS = 17;
    localparam int OFF_W     = 25;

    // result codes
    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_MORE   = 2'd1,
        ST_DONE   = 2'd2,
        ST_READ   = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic frag_acc;
        logic read_acc;
        logic div_load;
        logic div_step;
        logic mul_load;
        logic fin_eval;
        logic crc_step;
        logic crc_end;
        logic rd_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic hdr_last;
        logic div_done;
        logic need_crc;
        logic crc_done;
        logic out_free;
    } stat_t;

    // crc-16/ccitt over one byte, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data_in);
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/fragment_reassembler.sv =====
// fragment reassembler
// input channel (in_valid/in_ready) carries one transaction per fragment byte
// (kind 0) or per packet read (kind 1). the output channel (out_valid/out_ready)
// returns status, packet_length and read_data. config writes via cfg_write,
// cfg_index (0 magic, 1 version) and cfg_data, taken at once.
// a fragment byte that is not the last is taken with no result.
// after the tenth header byte, unless it is the last, the block stalls for the unit size
// divider and then for the offset multiply.
// a last byte is evaluated once the output register is free; with no crc walk its result is then registered.
// when the last fragment arrives the crc walk reads the store one byte a cycle
// over the one memory read port, then reports.
// a read transaction returns its reply once the output register is free.
// reset clears assembly state and config; store contents are undefined.
// when the receiver stalls, payload bytes keep being taken; a transaction with a
// result waits in its own state until the output register is free.
module fragment_reassembler #(
    parameter int BUFFER_BYTES = 512,
    parameter int MAX_FRAGS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic [8:0] read_address,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [9:0] packet_length,
    output logic [7:0] read_data
);
    import frag_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // sequencer
    frag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .last_byte (last_byte),
        .in_ready  (in_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath with store
    frag_dp #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_FRAGS    (MAX_FRAGS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .data_byte     (data_byte),
        .read_address  (read_address),
        .cmd           (cmd),
        .st            (st),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .packet_length (packet_length),
        .read_data     (read_data)
    );

endmodule

// ===== hw/rtl/frag_ctrl.sv =====
module frag_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          kind,
    input  logic          last_byte,
    output logic          in_ready,
    input  frag_pkg::stat_t st,
    output frag_pkg::cmd_t  cmd
);
    import frag_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_FIN  = 7'b0001000,
        S_CRC  = 7'b0010000,
        S_CEND = 7'b0100000,
        S_RDO  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   acc;

    assign in_ready = (state_reg == S_IDLE);
    assign acc      = in_valid && in_ready;

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.frag_acc = acc && !kind;
        cmd.read_acc = acc && kind;
        cmd.div_load = acc && !kind && !last_byte && st.hdr_last;
        cmd.div_step = (state_reg == S_DIV);
        cmd.mul_load = (state_reg == S_MUL);
        cmd.fin_eval = (state_reg == S_FIN) && st.out_free;
        cmd.crc_step = (state_reg == S_CRC);
        cmd.crc_end  = (state_reg == S_CEND) && st.out_free;
        cmd.rd_out   = (state_reg == S_RDO) && st.out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (kind)
                        state_next = S_RDO;
                    else if (last_byte)
                        state_next = S_FIN;
                    else if (st.hdr_last)
                        state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                    state_next = S_MUL;
            end
            S_MUL:  state_next = S_IDLE;
            S_FIN:
            begin
                if (st.out_free)
                    state_next = st.need_crc ? S_CRC : S_IDLE;
            end
            S_CRC:
            begin
                if (st.crc_done)
                    state_next = S_CEND;
            end
            S_CEND:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            S_RDO:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/frag_dp.sv =====
module frag_dp #(
    parameter int BUFFER_BYTES = 512,
    parameter int MAX_FRAGS    = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_data,
    input  logic [7:0]      data_byte,
    input  logic [8:0]      read_address,
    input  frag_pkg::cmd_t  cmd,
    output frag_pkg::stat_t st,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      status,
    output logic [9:0]      packet_length,
    output logic [7:0]      read_data
);
    import frag_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    // configuration
    logic [7:0] magic_reg, version_reg;

    // assembly state
    logic                 asm_reg;
    logic [15:0]          cur_reg;
    logic [15:0]          len_reg;
    logic [15:0]          chk_reg;
    logic [7:0]           frag_reg;
    logic [MAX_FRAGS-1:0] map_reg;
    logic [7:0]           hdr_reg [HDR_BYTES];
    logic [POS_W-1:0]     pos_reg;
    logic                 bad_reg;
    logic                 readable_reg;

    // divider and offset
    logic [DIV_W-1:0] quo_reg;
    logic [7:0]       rem_reg;
    logic [4:0]       div_cnt_reg;
    logic [DIV_W-1:0] unit_reg;
    logic [OFF_W-1:0] off_reg;

    // crc walk
    logic [15:0] crc_reg;
    logic [15:0] crc_idx_reg;
    logic        crc_pend_reg;

    // store
    logic [7:0]  mem [BUFFER_BYTES];
    logic [7:0]  mem_q_reg;
    logic        rd_lt_reg;

    // output stage
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [9:0]  plen_reg;
    logic [7:0]  rdata_reg;

    // header fields
    logic [7:0]  h_idx, h_cnt;
    logic [15:0] h_id, h_tot, h_crc;
    logic        fok;

    assign h_id  = {hdr_reg[3], hdr_reg[2]};
    assign h_idx = hdr_reg[4];
    assign h_cnt = hdr_reg[5];
    assign h_tot = {hdr_reg[7], hdr_reg[6]};
    assign h_crc = {hdr_reg[9], hdr_reg[8]};
    assign fok   = (h_cnt != 8'd0) && ({1'b0, h_cnt} <= 9'(MAX_FRAGS)) && (h_idx < h_cnt)
                && (h_tot != 16'd0) && ({1'b0, h_tot} <= 17'(BUFFER_BYTES));

    // store write address for payload bytes
    logic [OFF_W:0] wr_addr;
    logic           wr_en;
    assign wr_addr = {1'b0, off_reg} + (OFF_W+1)'(pos_reg - POS_W'(HDR_BYTES));
    assign wr_en   = cmd.frag_acc && (pos_reg >= POS_W'(HDR_BYTES)) && !bad_reg && fok
                  && (wr_addr < (OFF_W+1)'(BUFFER_BYTES));

    // divider step
    logic [8:0] div_r2;
    logic       div_ge;
    assign div_r2 = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge = div_r2 >= {1'b0, h_cnt};

    // fragment end evaluation
    logic                 f_skip, f_restart, f_fail, f_all;
    logic [15:0]          e_len, e_chk;
    logic [7:0]           e_cnt;
    logic [MAX_FRAGS-1:0] e_map, idx_bit, wanted, map_new;
    logic [POS_W-1:0]     f_plen;
    logic [OFF_W:0]       f_want, f_end;

    always_comb
    begin
        for (int j = 0; j < MAX_FRAGS; j++)
        begin
            idx_bit[j] = (h_idx == 8'(j));
            wanted[j]  = (8'(j) < h_cnt);
        end
        f_skip    = (pos_reg <= POS_W'(HDR_BYTES)) || bad_reg;
        f_restart = !asm_reg || (cur_reg != h_id);
        e_len     = f_restart ? h_tot : len_reg;
        e_chk     = f_restart ? h_crc : chk_reg;
        e_cnt     = f_restart ? h_cnt : frag_reg;
        e_map     = f_restart ? '0 : map_reg;
        f_plen    = pos_reg - POS_W'(HDR_BYTES);
        f_want    = (h_idx + 8'd1 == h_cnt) ? ((OFF_W+1)'(h_tot) - {1'b0, off_reg})
                                           : (OFF_W+1)'(unit_reg);
        f_end     = {1'b0, off_reg} + (OFF_W+1)'(f_plen);
        f_fail    = !fok || (e_len != h_tot) || (e_chk != h_crc) || (e_cnt != h_cnt)
                 || ({1'b0, off_reg} >= (OFF_W+1)'(h_tot))
                 || ((OFF_W+1)'(f_plen) != f_want) || (f_end > (OFF_W+1)'(h_tot));
        map_new   = e_map | idx_bit;
        f_all     = (map_new == wanted);
    end

    // crc walk read issue
    logic crc_issue;
    assign crc_issue = cmd.crc_step && (crc_idx_reg < len_reg);

    logic [15:0] rd_ext;
    assign rd_ext = {7'd0, read_address};

    // status to controller
    assign st.hdr_last = (pos_reg == POS_W'(HDR_BYTES - 1));
    assign st.div_done = (div_cnt_reg == 5'd1);
    assign st.need_crc = !f_skip && !f_fail && f_all;
    assign st.crc_done = (crc_idx_reg == len_reg) && !crc_pend_reg;
    assign st.out_free = !out_valid_reg || out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= 8'd0;
            version_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_MAGIC)
                magic_reg <= cfg_data;
            else if (cfg_index == CFG_VERSION)
                version_reg <= cfg_data;
        end
    end

    // fragment byte tracking and assembly state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_reg      <= 1'b0;
            cur_reg      <= '0;
            len_reg      <= '0;
            chk_reg      <= '0;
            frag_reg     <= '0;
            map_reg      <= '0;
            pos_reg      <= '0;
            bad_reg      <= 1'b0;
            readable_reg <= 1'b0;
            for (int i = 0; i < HDR_BYTES; i++)
                hdr_reg[i] <= 8'd0;
        end
        else
        begin
            if (cmd.frag_acc)
            begin
                readable_reg <= 1'b0;
                if (pos_reg < POS_W'(HDR_BYTES))
                begin
                    hdr_reg[pos_reg[3:0]] <= data_byte;
                    if ((pos_reg == POS_W'(0) && data_byte != magic_reg)
                        || (pos_reg == POS_W'(1) && data_byte != version_reg))
                        bad_reg <= 1'b1;
                end
                if (pos_reg < POS_MAX)
                    pos_reg <= pos_reg + POS_W'(1);
            end
            if (cmd.fin_eval)
            begin
                pos_reg <= '0;
                bad_reg <= 1'b0;
                for (int i = 0; i < HDR_BYTES; i++)
                    hdr_reg[i] <= 8'd0;
                if (!f_skip)
                begin
                    if (f_fail)
                    begin
                        asm_reg  <= 1'b0;
                        cur_reg  <= '0;
                        len_reg  <= '0;
                        chk_reg  <= '0;
                        frag_reg <= '0;
                        map_reg  <= '0;
                    end
                    else
                    begin
                        asm_reg  <= 1'b1;
                        cur_reg  <= h_id;
                        len_reg  <= e_len;
                        chk_reg  <= e_chk;
                        frag_reg <= e_cnt;
                        map_reg  <= map_new;
                    end
                end
            end
            if (cmd.crc_end)
            begin
                asm_reg  <= 1'b0;
                cur_reg  <= '0;
                chk_reg  <= '0;
                frag_reg <= '0;
                map_reg  <= '0;
                if (crc_reg == chk_reg)
                    readable_reg <= 1'b1;
                else
                    len_reg <= '0;
            end
        end
    end

    // unit size divider and fragment offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_load)
            div_cnt_reg <= 5'(DIV_STEPS);
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg - 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg <= {1'b0, h_tot} + DIV_W'(h_cnt) - DIV_W'(1);
            rem_reg <= 8'd0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], div_ge};
            rem_reg <= div_ge ? 8'(div_r2 - {1'b0, h_cnt}) : div_r2[7:0];
            if (st.div_done)
                unit_reg <= {quo_reg[DIV_W-2:0], div_ge};
        end
        if (cmd.mul_load)
            off_reg <= OFF_W'(h_idx * unit_reg);
    end

    // crc walk over the stored packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= 16'hFFFF;
            crc_idx_reg  <= '0;
            crc_pend_reg <= 1'b0;
        end
        else if (cmd.fin_eval)
        begin
            crc_reg      <= 16'hFFFF;
            crc_idx_reg  <= '0;
            crc_pend_reg <= 1'b0;
        end
        else if (cmd.crc_step)
        begin
            crc_pend_reg <= crc_issue;
            if (crc_issue)
                crc_idx_reg <= crc_idx_reg + 16'd1;
            if (crc_pend_reg)
                crc_reg <= crc16_byte(crc_reg, mem_q_reg);
        end
    end

    // packet store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[AW-1:0]] <= data_byte;
        if (cmd.read_acc)
        begin
            mem_q_reg <= mem[rd_ext[AW-1:0]];
            rd_lt_reg <= (rd_ext < len_reg) && ({1'b0, rd_ext} < 17'(BUFFER_BYTES));
        end
        else if (crc_issue)
            mem_q_reg <= mem[crc_idx_reg[AW-1:0]];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((cmd.fin_eval && !st.need_crc) || cmd.crc_end || cmd.rd_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_eval && !st.need_crc)
        begin
            status_reg <= (!f_skip && !f_fail) ? ST_MORE : ST_REJECT;
            plen_reg   <= 10'd0;
            rdata_reg  <= 8'd0;
        end
        else if (cmd.crc_end)
        begin
            status_reg <= (crc_reg == chk_reg) ? ST_DONE : ST_REJECT;
            plen_reg   <= (crc_reg == chk_reg) ? len_reg[9:0] : 10'd0;
            rdata_reg  <= 8'd0;
        end
        else if (cmd.rd_out)
        begin
            status_reg <= readable_reg ? ST_READ : ST_REJECT;
            plen_reg   <= readable_reg ? len_reg[9:0] : 10'd0;
            rdata_reg  <= (readable_reg && rd_lt_reg) ? mem_q_reg : 8'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign packet_length = plen_reg;
    assign read_data     = rdata_reg;

    // a readable packet means no assembly is open
    a_readable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        readable_reg |-> !asm_reg)
        else $error("readable packet with assembly open");

    // received fragments only exist within an open assembly
    a_map_asm: assert property (@(posedge clk) disable iff (!rst_n)
        (map_reg != '0) |-> asm_reg)
        else $error("fragment bitmap set without assembly");

    // a bad fragment has at least one byte counted
    a_bad_pos: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg |-> (pos_reg != '0))
        else $error("bad fragment flag at byte zero");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import frag_pkg::*;

    localparam int BUF_BYTES  = 512;
    localparam int FRAG_LIMIT = 64;
    localparam int HDR_LEN    = 10;
    localparam int POS_SAT    = 2047;
    localparam int DRAIN_CYC  = 600;
    localparam int WATCHDOG   = 4000;
    localparam int HOLD_CYC   = 400;
    localparam int PHASE_TXNS = 470;

    // one input transaction, with an optional typed-in expectation
    typedef struct {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [8:0] read_address;
        bit         typed;
        status_t    t_status;
        logic [9:0] t_length;
        logic [7:0] t_data;
    } txn_t;

    typedef struct {
        status_t    status;
        logic [9:0] packet_length;
        logic [7:0] read_data;
    } reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = CFG_MAGIC;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic [9:0] packet_length;
    logic [7:0] read_data;
    txn_t       cur = '{kind: 1'b0, data_byte: 8'd0, last_byte: 1'b0, read_address: 9'd0,
                        typed: 1'b0, t_status: ST_REJECT, t_length: 10'd0, t_data: 8'd0};

    fragment_reassembler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (cur.kind),
        .data_byte    (cur.data_byte),
        .last_byte    (cur.last_byte),
        .read_address (cur.read_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .packet_length(packet_length),
        .read_data    (read_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow state of the reassembler
    logic [7:0]  m_magic;
    logic [7:0]  m_version;
    bit          m_assembling;
    int          m_msg_id;
    int          m_msg_len;
    int          m_crc;
    int          m_frag_total;
    logic [63:0] m_rx_map;
    logic [7:0]  m_store [BUF_BYTES];
    logic [7:0]  m_hdr [HDR_LEN];
    int          m_pos;
    bit          m_frag_bad;
    bit          m_readable;

    reply_t reply_q[$];
    txn_t   stim_q[$];
    int     err_count = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    bit     hold_req = 0;
    bit     hold_taken = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;
    logic [7:0] gen_magic;
    logic [7:0] gen_version;

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
        logic [15:0] r;
        r = c ^ {d, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ 16'h1021;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic int hdr_word(int at);
        return int'(m_hdr[at]) | (int'(m_hdr[at+1]) << 8);
    endfunction

    function automatic bit hdr_fields_ok();
        int idx, cnt, tot;
        idx = m_hdr[4];
        cnt = m_hdr[5];
        tot = hdr_word(6);
        return cnt != 0 && cnt <= FRAG_LIMIT && idx < cnt && tot != 0 && tot <= BUF_BYTES;
    endfunction

    function automatic int hdr_unit();
        return (hdr_word(6) + int'(m_hdr[5]) - 1) / int'(m_hdr[5]);
    endfunction

    task automatic clear_assembly();
        m_assembling = 0;
        m_msg_id = 0;
        m_msg_len = 0;
        m_crc = 0;
        m_frag_total = 0;
        m_rx_map = '0;
    endtask

    task automatic reset_model();
        m_magic = 8'd0;
        m_version = 8'd0;
        clear_assembly();
        for (int i = 0; i < BUF_BYTES; i++)
            m_store[i] = 8'd0;
        for (int i = 0; i < HDR_LEN; i++)
            m_hdr[i] = 8'd0;
        m_pos = 0;
        m_frag_bad = 0;
        m_readable = 0;
    endtask

    // verdict for a fragment that has just ended
    task automatic close_fragment(output reply_t r);
        int id, idx, cnt, tot, crc, unit, off, plen, want;
        logic [63:0] full;
        logic [15:0] c;
        r = '{status: ST_REJECT, packet_length: 10'd0, read_data: 8'd0};
        if (m_pos <= HDR_LEN || m_frag_bad)
            return;
        if (!hdr_fields_ok())
        begin
            clear_assembly();
            return;
        end
        id = hdr_word(2);
        idx = m_hdr[4];
        cnt = m_hdr[5];
        tot = hdr_word(6);
        crc = hdr_word(8);
        if (!m_assembling || m_msg_id != id)
        begin
            clear_assembly();
            m_assembling = 1;
            m_msg_id = id;
            m_msg_len = tot;
            m_crc = crc;
            m_frag_total = cnt;
        end
        if (m_msg_len != tot || m_crc != crc || m_frag_total != cnt)
        begin
            clear_assembly();
            return;
        end
        unit = hdr_unit();
        off = idx * unit;
        plen = m_pos - HDR_LEN;
        if (off >= tot)
        begin
            clear_assembly();
            return;
        end
        want = (idx + 1 == cnt) ? tot - off : unit;
        if (plen != want || off + plen > tot)
        begin
            clear_assembly();
            return;
        end
        m_rx_map[idx] = 1'b1;
        full = (cnt >= 64) ? '1 : ((64'd1 << cnt) - 64'd1);
        if (m_rx_map != full)
        begin
            r.status = ST_MORE;
            return;
        end
        c = 16'hFFFF;
        for (int i = 0; i < tot; i++)
            c = crc_next(c, m_store[i]);
        clear_assembly();
        if (int'(c) != crc)
            return;
        m_msg_len = tot;
        m_readable = 1;
        r.status = ST_DONE;
        r.packet_length = tot[9:0];
    endtask

    // expected reply, if any, for one accepted transaction
    task automatic predict_reply(input txn_t t, output bit has, output reply_t r);
        int a;
        has = 0;
        r = '{status: ST_REJECT, packet_length: 10'd0, read_data: 8'd0};
        if (t.kind)
        begin
            has = 1;
            if (m_readable)
            begin
                r.status = ST_READ;
                r.packet_length = m_msg_len[9:0];
                if (int'(t.read_address) < m_msg_len)
                    r.read_data = m_store[t.read_address];
            end
            return;
        end
        m_readable = 0;
        if (m_pos < HDR_LEN)
        begin
            m_hdr[m_pos] = t.data_byte;
            if ((m_pos == 0 && t.data_byte != m_magic) ||
                (m_pos == 1 && t.data_byte != m_version))
                m_frag_bad = 1;
        end
        else if (!m_frag_bad && hdr_fields_ok())
        begin
            a = int'(m_hdr[4]) * hdr_unit() + (m_pos - HDR_LEN);
            if (a < BUF_BYTES)
                m_store[a] = t.data_byte;
        end
        if (m_pos < POS_SAT)
            m_pos++;
        if (!t.last_byte)
            return;
        has = 1;
        close_fragment(r);
        m_pos = 0;
        m_frag_bad = 0;
        for (int i = 0; i < HDR_LEN; i++)
            m_hdr[i] = 8'd0;
    endtask

    // prediction, checking and watchdog at every edge
    always @(posedge clk)
    begin
        bit     has;
        reply_t r;
        reply_t e;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (in_valid || reply_q.size() != 0)
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("timeout with %0d replies outstanding", reply_q.size());
                $display("FAIL fragment_reassembler");
                $finish;
            end
            if (in_valid && in_ready)
            begin
                predict_reply(cur, has, r);
                if (cur.typed)
                begin
                    has = 1;
                    r = '{status: cur.t_status, packet_length: cur.t_length,
                          read_data: cur.t_data};
                end
                if (has)
                    reply_q.push_back(r);
            end
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    err_count <= err_count + 1;
                    if (err_count < 10)
                        $display("unexpected reply status=%0d len=%0d data=%0d",
                                 status, packet_length, read_data);
                end
                else
                begin
                    e = reply_q.pop_front();
                    if (status != e.status || packet_length != e.packet_length ||
                        read_data != e.read_data)
                    begin
                        err_count <= err_count + 1;
                        if (err_count < 10)
                            $display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     e.status, e.packet_length, e.read_data,
                                     status, packet_length, read_data);
                    end
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_byte(logic [7:0] d, logic last);
        txn_t t;
        t = '{kind: 1'b0, data_byte: d, last_byte: last, read_address: 9'($urandom),
              typed: 1'b0, t_status: ST_REJECT, t_length: 10'd0, t_data: 8'd0};
        stim_q.push_back(t);
    endtask

    task automatic push_read(logic [8:0] a);
        txn_t t;
        t = '{kind: 1'b1, data_byte: 8'($urandom), last_byte: 1'($urandom), read_address: a,
              typed: 1'b0, t_status: ST_REJECT, t_length: 10'd0, t_data: 8'd0};
        stim_q.push_back(t);
    endtask

    task automatic push_typed(logic kind, logic [7:0] d, logic last, logic [8:0] a,
                              status_t st, logic [9:0] len, logic [7:0] rd);
        txn_t t;
        t = '{kind: kind, data_byte: d, last_byte: last, read_address: a,
              typed: 1'b1, t_status: st, t_length: len, t_data: rd};
        stim_q.push_back(t);
    endtask

    // one message cut into fragments, sent in random order with rare faults
    task automatic gen_message(int tot, int cnt, int pad);
        logic [7:0]  msg[$];
        logic [7:0]  frag[$];
        logic [7:0]  h[HDR_LEN];
        int          order[$];
        int          unit, off, len, fault, j, tmp, keep;
        logic [15:0] c;
        logic [15:0] id;
        logic [15:0] v;
        if (tot == 0)
            tot = ($urandom_range(19) == 0) ? $urandom_range(41, BUF_BYTES) :
                                               $urandom_range(1, 40);
        if (cnt == 0)
            cnt = ($urandom_range(29) == 0) ? $urandom_range(1, FRAG_LIMIT) :
                                               $urandom_range(1, (tot < 5) ? tot : 5);
        id = 16'($urandom);
        c = 16'hFFFF;
        for (int i = 0; i < tot; i++)
        begin
            msg.push_back(8'($urandom));
            c = crc_next(c, msg[i]);
        end
        if ($urandom_range(19) == 0)
            c = c ^ 16'(($urandom_range(1, 65535)));
        unit = (tot + cnt - 1) / cnt;
        for (int i = 0; i < cnt; i++)
            order.push_back(i);
        for (int i = cnt - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[k])
        begin
            off = order[k] * unit;
            len = (order[k] == cnt - 1) ? tot - off : unit;
            if (len < 0)
                len = 0;
            h[0] = gen_magic;
            h[1] = gen_version;
            h[2] = id[7:0];
            h[3] = id[15:8];
            h[4] = 8'(order[k]);
            h[5] = 8'(cnt);
            h[6] = 8'(tot);
            h[7] = 8'(tot >> 8);
            h[8] = c[7:0];
            h[9] = c[15:8];
            fault = ($urandom_range(99) < 8) ? $urandom_range(1, 10) : 0;
            case (fault)
                1: h[0] = h[0] ^ 8'($urandom_range(1, 255));
                2: h[1] = h[1] ^ 8'($urandom_range(1, 255));
                4: h[5] = 8'd0;
                5: h[5] = 8'($urandom_range(FRAG_LIMIT + 1, 255));
                6: h[4] = 8'(cnt + $urandom_range(0, 255 - cnt));
                7:
                begin
                    v = ($urandom_range(1)) ? 16'd0 : 16'($urandom_range(BUF_BYTES + 1, 65535));
                    h[6] = v[7:0];
                    h[7] = v[15:8];
                end
                9: h[8] = h[8] ^ 8'($urandom_range(1, 255));
                default: ;
            endcase
            frag.delete();
            for (int i = 0; i < HDR_LEN; i++)
                frag.push_back(h[i]);
            for (int i = 0; i < len; i++)
                frag.push_back(msg[off + i]);
            for (int i = 0; i < pad; i++)
                frag.push_back(8'($urandom));
            if (fault == 8)
            begin
                if ($urandom_range(1))
                    void'(frag.pop_back());
                else
                    frag.push_back(8'($urandom));
            end
            if (fault == 3)
            begin
                keep = $urandom_range(1, HDR_LEN);
                while (frag.size() > keep)
                    void'(frag.pop_back());
            end
            for (int rep = 0; rep < ((fault == 10) ? 2 : 1); rep++)
                foreach (frag[i])
                    push_byte(frag[i], i == frag.size() - 1);
            if ($urandom_range(29) == 0)
                push_read(9'($urandom));
        end
        for (int i = $urandom_range(0, 4); i > 0; i--)
            push_read(($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(0, tot - 1)));
    endtask

    task automatic write_config(logic [7:0] magic, logic [7:0] version);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAGIC;
        cfg_data <= magic;
        @(posedge clk);
        cfg_index <= CFG_VERSION;
        cfg_data <= version;
        @(posedge clk);
        cfg_write <= 1'b0;
        m_magic = magic;
        m_version = version;
        gen_magic = magic;
        gen_version = version;
    endtask

    // send everything queued, then wait for all replies and a quiet stretch
    task automatic send_all();
        txn_t t;
        int   n;
        n = 0;
        while (stim_q.size() != 0)
        begin
            t = stim_q.pop_front();
            if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_valid <= 1'b1;
            cur <= t;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            n++;
            if (n == 100 && stall_pct == 0 && idle_pct == 0)
                hold_req = 1;
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    initial
    begin
        int          idle_tab[4];
        int          stall_tab[4];
        logic [7:0]  mg[4];
        logic [7:0]  vr[4];
        logic [15:0] c;
        idle_tab = '{0, 83, 0, 35};
        stall_tab = '{0, 0, 83, 35};
        mg = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        vr = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_config(8'hA5, 8'h5A);

        // directed: read before any packet, short, bad version, one-byte packet
        push_typed(1'b1, 8'h00, 1'b0, 9'd0, ST_REJECT, 10'd0, 8'd0);
        push_byte(8'hA5, 1'b0);
        push_typed(1'b0, 8'h5A, 1'b1, 9'd0, ST_REJECT, 10'd0, 8'd0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h00, 1'b0);
        for (int i = 0; i < 8; i++)
            push_byte(8'h11, 1'b0);
        push_typed(1'b0, 8'h22, 1'b1, 9'd0, ST_REJECT, 10'd0, 8'd0);
        c = crc_next(16'hFFFF, 8'hFF);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(c[7:0], 1'b0);
        push_byte(c[15:8], 1'b0);
        push_typed(1'b0, 8'hFF, 1'b1, 9'd0, ST_DONE, 10'd1, 8'd0);
        push_typed(1'b1, 8'h00, 1'b0, 9'd0, ST_READ, 10'd1, 8'hFF);
        push_typed(1'b1, 8'hFF, 1'b1, 9'd511, ST_READ, 10'd1, 8'd0);
        send_all();

        // random phases over several settings and idling patterns
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = idle_tab[p];
            stall_pct = stall_tab[p];
            write_config(mg[p], vr[p]);
            if (p == 1)
                gen_message(BUF_BYTES, 8, 0);
            if (p == 2)
                gen_message(20, 1, 2040);
            while (stim_q.size() < PHASE_TXNS)
                gen_message(0, 0, 0);
            send_all();
        end

        if (err_count == 0)
            $display("PASS fragment_reassembler");
        else
            $display("FAIL fragment_reassembler");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/frag_pkg.sv
hw/rtl/frag_ctrl.sv
hw/rtl/frag_dp.sv
hw/rtl/fragment_reassembler.sv
bench/tb.sv
